FILE: rtl/triangle_tangent_generator_core_macros.svh
// Assertion helpers for the tangent generator RTL.
`ifndef TRIANGLE_TANGENT_GENERATOR_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_GENERATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TTG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next edge.
`define TTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define TTG_ASSERT(lbl, clk, rstn, prop, msg)
`define TTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: rtl/ttg_pkg.sv
package ttg_pkg;

  // Field and datapath widths
  localparam int CoordW    = 16;
  localparam int DeltaW    = CoordW + 1;
  localparam int ProdW     = 2 * DeltaW;
  localparam int TanW      = ProdW + 1;
  localparam int MagW      = TanW - 1;
  localparam int NormW     = 30;
  localparam int SumW      = 2 * NormW + 2;
  localparam int RootW     = NormW + 1;
  localparam int UnitShift = 14;
  localparam int QuotW     = UnitShift + 1;
  localparam int AluW      = SumW;
  localparam int MulW      = 32;
  localparam int OutW      = 16;
  localparam int NumAxes   = 3;
  localparam int CntW      = 4;

  localparam logic signed [OutW-1:0] UnitPos = OutW'(1 << UnitShift);
  localparam logic signed [OutW-1:0] UnitNeg = -UnitPos;

  // One incoming vertex
  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] pz;
    logic signed [CoordW-1:0] tu;
    logic signed [CoordW-1:0] tv;
  } ttg_vertex_t;

  // Edges and UV deltas of one triangle
  typedef struct packed {
    logic signed [DeltaW-1:0] e1x;
    logic signed [DeltaW-1:0] e1y;
    logic signed [DeltaW-1:0] e1z;
    logic signed [DeltaW-1:0] e2x;
    logic signed [DeltaW-1:0] e2y;
    logic signed [DeltaW-1:0] e2z;
    logic signed [DeltaW-1:0] du1;
    logic signed [DeltaW-1:0] dv1;
    logic signed [DeltaW-1:0] du2;
    logic signed [DeltaW-1:0] dv2;
  } ttg_delta_t;

  // One finished tangent
  typedef struct packed {
    logic signed [OutW-1:0] tx;
    logic signed [OutW-1:0] ty;
    logic signed [OutW-1:0] tz;
    logic                   degenerate;
  } ttg_result_t;

  // Engine status toward the stream logic
  typedef struct packed {
    logic idle;
    logic done;
  } ttg_status_t;

endpackage

FILE: rtl/triangle_tangent_generator_core.sv
// Per-triangle tangent generator.
// The input stream carries one vertex per transaction in triangle order:
// tdata holds position x, y, z (Q8.8) and texture u, v (Q4.12).
// The first two vertices of a triangle are held.
// The third vertex starts the engine, which yields one unit tangent (Q1.14)
// on the output stream, with tuser set when the triangle is degenerate.
// The engine runs one shared 32x32 multiplier for the determinant, the tangent
// and the squared length, then one shared compare-subtract unit for a bit-
// serial square root and three restoring divides.
// s_axis_tready is low while the engine works on a triangle.
// Results pass through an output register, so the next vertices are accepted
// while a result waits; a stalled receiver holds the engine in its final
// state once a second result is ready.
// Reset clears the corner count, the engine and the output valid.
module triangle_tangent_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x[15:0], pos_y[31:16], pos_z[47:32], tex_u[63:48], tex_v[79:64]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tangent_x[15:0], tangent_y[31:16], tangent_z[47:32]
  output logic [47:0] m_axis_tdata,
  // degenerate[0]
  output logic [0:0]  m_axis_tuser
);
  import ttg_pkg::*;

  `include "triangle_tangent_generator_core_macros.svh"

  ttg_vertex_t vertex;
  ttg_delta_t  delta;
  ttg_status_t status;
  ttg_result_t result;
  ttg_result_t out_q;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;
  logic        eng_start;
  logic        out_load;

  // Unpack the vertex
  assign vertex.px = s_axis_tdata[15:0];
  assign vertex.py = s_axis_tdata[31:16];
  assign vertex.pz = s_axis_tdata[47:32];
  assign vertex.tu = s_axis_tdata[63:48];
  assign vertex.tv = s_axis_tdata[79:64];

  assign s_axis_tready = status.idle;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  ttg_corners u_corners (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .vertex_i (vertex),
    .start_o  (eng_start),
    .delta_o  (delta)
  );

  ttg_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eng_start),
    .delta_i  (delta),
    .ack_i    (out_load),
    .status_o (status),
    .result_o (result)
  );

  // Move a finished result into the output register when it is free
  assign out_load = status.done && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {out_q.tz, out_q.ty, out_q.tx};
  assign m_axis_tuser[0] = out_q.degenerate;

  // A degenerate result carries a zero tangent
  `TTG_ASSERT(a_degen_zero, clk_i, rst_ni, !(out_valid_q && out_q.degenerate) || (m_axis_tdata == '0), "degenerate result with nonzero tangent")

  // A finished result is held while the output register stays occupied
  `TTG_ASSERT_NEXT(a_done_held, clk_i, rst_ni, status.done && out_valid_q && !m_axis_tready, status.done, "finished result dropped under stall")

  // The x component of the unit tangent stays within one
  `TTG_ASSERT(a_tan_range, clk_i, rst_ni, !out_valid_q || (out_q.tx <= UnitPos && out_q.tx >= UnitNeg), "tangent x out of unit range")

endmodule

FILE: rtl/ttg_corners.sv
module ttg_corners (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  ttg_pkg::ttg_vertex_t vertex_i,
  output logic                 start_o,
  output ttg_pkg::ttg_delta_t  delta_o
);
  import ttg_pkg::*;

  logic [1:0]  count_q, count_d;
  ttg_vertex_t held_q [2];

  function automatic logic signed [DeltaW-1:0] sdiff(logic signed [CoordW-1:0] a,
                                                     logic signed [CoordW-1:0] b);
    return DeltaW'(a) - DeltaW'(b);
  endfunction

  // A held count of two or more means this vertex closes the triangle
  assign start_o = accept_i && count_q[1];

  // Advance the corner count
  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      count_d = count_q[1] ? 2'd0 : count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Hold the first two corners
  always_ff @(posedge clk_i) begin
    if (accept_i && !count_q[1]) begin
      held_q[count_q[0]] <= vertex_i;
    end
  end

  // Form edges and UV deltas against the first corner
  always_comb begin
    delta_o.e1x = sdiff(held_q[1].px, held_q[0].px);
    delta_o.e1y = sdiff(held_q[1].py, held_q[0].py);
    delta_o.e1z = sdiff(held_q[1].pz, held_q[0].pz);
    delta_o.e2x = sdiff(vertex_i.px, held_q[0].px);
    delta_o.e2y = sdiff(vertex_i.py, held_q[0].py);
    delta_o.e2z = sdiff(vertex_i.pz, held_q[0].pz);
    delta_o.du1 = sdiff(held_q[1].tu, held_q[0].tu);
    delta_o.dv1 = sdiff(held_q[1].tv, held_q[0].tv);
    delta_o.du2 = sdiff(vertex_i.tu, held_q[0].tu);
    delta_o.dv2 = sdiff(vertex_i.tv, held_q[0].tv);
  end

endmodule

FILE: rtl/ttg_mult.sv
module ttg_mult (
  input  logic                                clk_i,
  input  logic signed [ttg_pkg::MulW-1:0]     a_i,
  input  logic signed [ttg_pkg::MulW-1:0]     b_i,
  output logic signed [2*ttg_pkg::MulW-1:0]   p_o
);
  import ttg_pkg::*;

  logic signed [2*MulW-1:0] p_q;

  // Register every product
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/ttg_cmpsub.sv
module ttg_cmpsub (
  input  logic [ttg_pkg::AluW-1:0] a_i,
  input  logic [ttg_pkg::AluW-1:0] b_i,
  output logic [ttg_pkg::AluW-1:0] diff_o,
  output logic                     ge_o
);
  import ttg_pkg::*;

  logic [AluW:0] full;

  // Subtract with borrow out; no borrow means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[AluW-1:0];
  assign ge_o   = !full[AluW];

endmodule

FILE: rtl/ttg_engine.sv
module ttg_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ttg_pkg::ttg_delta_t  delta_i,
  input  logic                 ack_i,
  output ttg_pkg::ttg_status_t status_o,
  output ttg_pkg::ttg_result_t result_o
);
  import ttg_pkg::*;

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StMul    = 10'b00_0000_0010,
    StAbs    = 10'b00_0000_0100,
    StMax    = 10'b00_0000_1000,
    StNorm   = 10'b00_0001_0000,
    StSquare = 10'b00_0010_0000,
    StRoot   = 10'b00_0100_0000,
    StDivSet = 10'b00_1000_0000,
    StDiv    = 10'b01_0000_0000,
    StDone   = 10'b10_0000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        axis_q, axis_d;

  ttg_delta_t               dlt_q;
  logic signed [ProdW-1:0]  acc_q;
  logic                     det_neg_q;
  logic                     det_zero_q;
  logic signed [TanW-1:0]   t_q   [NumAxes];
  logic [MagW-1:0]          mag_q [NumAxes];
  logic                     neg_q [NumAxes];
  logic [MagW-1:0]          mx_q;
  logic [SumW-1:0]          sum_q;
  logic [SumW-1:0]          rad_q;
  logic [SumW-1:0]          root_q;
  logic [SumW-1:0]          bit_q;
  logic [AluW-1:0]          rem_q;
  logic [AluW-1:0]          dsh_q;
  logic [QuotW-1:0]         quo_q;
  logic signed [OutW-1:0]   tan_q [NumAxes];
  logic                     deg_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_p;
  logic signed [ProdW-1:0]  prod_s;
  logic signed [TanW-1:0]   diff_s;
  logic [CntW-1:0]          step;
  logic [AluW-1:0]          alu_a, alu_b, alu_diff;
  logic                     alu_ge;
  logic [MagW-1:0]          mx_01, mx_c;
  logic [QuotW-1:0]         quo_fin;
  logic signed [OutW-1:0]   quo_ext;

  // Shared multiplier
  ttg_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Shared compare and subtract unit
  ttg_cmpsub u_cmpsub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  function automatic logic signed [MulW-1:0] sx(logic signed [DeltaW-1:0] v);
    return MulW'(v);
  endfunction

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == StMul) begin
      case (cnt_q)
        4'd0:    begin mul_a = sx(dlt_q.du1); mul_b = sx(dlt_q.dv2); end
        4'd1:    begin mul_a = sx(dlt_q.du2); mul_b = sx(dlt_q.dv1); end
        4'd2:    begin mul_a = sx(dlt_q.dv2); mul_b = sx(dlt_q.e1x); end
        4'd3:    begin mul_a = sx(dlt_q.dv1); mul_b = sx(dlt_q.e2x); end
        4'd4:    begin mul_a = sx(dlt_q.dv2); mul_b = sx(dlt_q.e1y); end
        4'd5:    begin mul_a = sx(dlt_q.dv1); mul_b = sx(dlt_q.e2y); end
        4'd6:    begin mul_a = sx(dlt_q.dv2); mul_b = sx(dlt_q.e1z); end
        4'd7:    begin mul_a = sx(dlt_q.dv1); mul_b = sx(dlt_q.e2z); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == StSquare && cnt_q < 4'(NumAxes)) begin
      mul_a = MulW'(mag_q[cnt_q[1:0]][NormW-1:0]);
      mul_b = MulW'(mag_q[cnt_q[1:0]][NormW-1:0]);
    end
  end

  // Product of the previous step and the running difference
  assign prod_s = mul_p[ProdW-1:0];
  assign diff_s = TanW'(acc_q) - TanW'(prod_s);
  assign step   = cnt_q - 4'd1;

  // Route the subtract unit to the root or divide loop
  always_comb begin
    if (state_q == StRoot) begin
      alu_a = rad_q;
      alu_b = root_q | bit_q;
    end else begin
      alu_a = rem_q;
      alu_b = dsh_q;
    end
  end

  // Largest magnitude
  assign mx_01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
  assign mx_c  = (mx_01 > mag_q[2]) ? mx_01 : mag_q[2];

  // Final quotient bit joins the partial quotient
  assign quo_fin = {quo_q[QuotW-2:0], alu_ge};
  assign quo_ext = OutW'(quo_fin);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    axis_d  = axis_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StMul;
          cnt_d   = '0;
        end
      end
      StMul: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(2 * (NumAxes + 1))) begin
          state_d = StAbs;
        end
      end
      StAbs: state_d = StMax;
      StMax: begin
        state_d = (det_zero_q || mx_c == '0) ? StDone : StNorm;
      end
      StNorm: begin
        if (mx_q[MagW-1:NormW] == '0 && mx_q[NormW-1]) begin
          state_d = StSquare;
          cnt_d   = '0;
        end
      end
      StSquare: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(NumAxes)) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (bit_q[0]) begin
          state_d = StDivSet;
          axis_d  = '0;
        end
      end
      StDivSet: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'(QuotW - 1)) begin
          axis_d  = axis_q + 2'd1;
          state_d = (axis_q == 2'(NumAxes - 1)) ? StDone : StDivSet;
        end
      end
      StDone: begin
        if (ack_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      axis_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      axis_q  <= axis_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (start_i) begin
          dlt_q <= delta_i;
        end
      end
      StMul: begin
        // Even steps load the first product, odd steps take the difference
        if (cnt_q != '0) begin
          if (!step[0]) begin
            acc_q <= prod_s;
          end else if (step == 4'd1) begin
            det_neg_q  <= diff_s[TanW-1];
            det_zero_q <= (diff_s == '0);
          end else begin
            t_q[step[2:1] - 2'd1] <= diff_s;
          end
        end
      end
      StAbs: begin
        for (int i = 0; i < NumAxes; i++) begin
          neg_q[i] <= t_q[i][TanW-1] ^ det_neg_q;
          mag_q[i] <= t_q[i][TanW-1] ? MagW'(-t_q[i]) : MagW'(t_q[i]);
        end
      end
      StMax: begin
        mx_q <= mx_c;
        if (det_zero_q || mx_c == '0) begin
          for (int i = 0; i < NumAxes; i++) begin
            tan_q[i] <= '0;
          end
          deg_q <= 1'b1;
        end
      end
      StNorm: begin
        // Scale until the largest magnitude sits in its normal window
        if (mx_q[MagW-1:NormW] != '0) begin
          mx_q <= mx_q >> 1;
          for (int i = 0; i < NumAxes; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end else if (!mx_q[NormW-1]) begin
          mx_q <= mx_q << 1;
          for (int i = 0; i < NumAxes; i++) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
      end
      StSquare: begin
        if (cnt_q == 4'd1) begin
          sum_q <= mul_p[SumW-1:0];
        end else if (cnt_q == 4'(NumAxes)) begin
          rad_q  <= sum_q + mul_p[SumW-1:0];
          root_q <= '0;
          bit_q  <= SumW'(1) << (SumW - 2);
        end else if (cnt_q != '0) begin
          sum_q <= sum_q + mul_p[SumW-1:0];
        end
      end
      StRoot: begin
        // One root bit per cycle
        if (alu_ge) begin
          rad_q  <= alu_diff;
          root_q <= (root_q >> 1) | bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      StDivSet: begin
        rem_q <= AluW'({mag_q[axis_q][NormW-1:0], {UnitShift{1'b0}}})
               + AluW'(root_q[RootW-1:1]);
        dsh_q <= AluW'(root_q[RootW-1:0]) << UnitShift;
        quo_q <= '0;
      end
      StDiv: begin
        // One quotient bit per cycle
        if (alu_ge) begin
          rem_q <= alu_diff;
        end
        quo_q <= quo_fin;
        dsh_q <= dsh_q >> 1;
        if (cnt_q == 4'(QuotW - 1)) begin
          tan_q[axis_q] <= neg_q[axis_q] ? -quo_ext : quo_ext;
          deg_q         <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.idle       = (state_q == StIdle);
  assign status_o.done       = (state_q == StDone);
  assign result_o.tx         = tan_q[0];
  assign result_o.ty         = tan_q[1];
  assign result_o.tz         = tan_q[2];
  assign result_o.degenerate = deg_q;

endmodule
